[design/assert_macros.svh]
// Assertion macros used by the binning table back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define UGCL_ASSERT(name, clk, rstn, expr) \
    name: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
`define UGCL_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define UGCL_ASSERT(name, clk, rstn, expr)
`define UGCL_ASSERT_NEXT(name, clk, rstn, pre, post)
`endif
`endif

[design/ugcl_pkg.sv]
// Types and codes of the uniform grid cell list
package ugcl_pkg;

    localparam int COORD_W     = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int POS_W       = 24;
    localparam int SIZE_W      = 23;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_OK,
        ST_INVALID,
        ST_RANGE,
        ST_FULL,
        ST_NOT_FOUND
    } status_t;

    typedef enum logic [1:0] {
        K_INSERT,
        K_REMOVE,
        K_QUERY,
        K_STATUS
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [7:0]           id;
        status_t              status;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
    } item_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [4:0] {
        B_CLEAR,
        B_IDLE,
        B_LOOK,
        B_DEC,
        B_CNT_W,
        B_CNT,
        B_TK_C,
        B_TK_N,
        B_TK,
        B_TK_D,
        B_APPEND,
        B_Q_CELL,
        B_Q_CW,
        B_Q_CNT,
        B_Q_ENT,
        B_Q_DAT,
        B_Q_END,
        B_EMIT
    } back_state_t;

endpackage

[design/ugcl_front.sv]
// Front end: takes words, classifies them and bins insert positions
module ugcl_front #(
    parameter int GRID_COLS     = 16,
    parameter int GRID_ROWS     = 16,
    parameter int MAX_PARTICLES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [7:0]                  particle_id,
    input  logic [ugcl_pkg::POS_W-1:0]  pos_x,
    input  logic [ugcl_pkg::POS_W-1:0]  pos_y,
    input  logic                        pos_invalid,
    input  logic [ugcl_pkg::SIZE_W-1:0] cell_size,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ugcl_pkg::item_t             out_item
);

    localparam int SW = ugcl_pkg::SIZE_W;

    ugcl_pkg::front_state_t state_reg, state_next;
    ugcl_pkg::item_t        item_reg, item_next;
    logic                   negx_reg, negx_next, negy_reg, negy_next;
    logic [SW:0]            remx_reg, remx_next, remy_reg, remy_next;
    logic [SW-1:0]          qx_reg, qx_next, qy_reg, qy_next;
    logic [SW-1:0]          dvx_reg, dvx_next, dvy_reg, dvy_next;
    logic [4:0]             step_reg, step_next;

    logic [SW-1:0] cs;
    logic [SW:0]   tx, ty;
    logic          in_range;

    always_comb
    begin
        cs = (cell_size == '0) ? SW'(1) : cell_size;
        tx = {remx_reg[SW-1:0], dvx_reg[SW-1]};
        ty = {remy_reg[SW-1:0], dvy_reg[SW-1]};
        in_range = !negx_reg && !negy_reg
                   && (32'(qx_reg) < GRID_COLS) && (32'(qy_reg) < GRID_ROWS);
    end

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        negx_next  = negx_reg;
        negy_next  = negy_reg;
        remx_next  = remx_reg;
        remy_next  = remy_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        dvx_next   = dvx_reg;
        dvy_next   = dvy_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        out_item   = item_reg;
        case (state_reg)
            ugcl_pkg::F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next.id     = particle_id;
                    item_next.status = ugcl_pkg::ST_OK;
                    item_next.row    = '0;
                    item_next.col    = '0;
                    negx_next = pos_x[ugcl_pkg::POS_W-1];
                    negy_next = pos_y[ugcl_pkg::POS_W-1];
                    dvx_next  = pos_x[SW-1:0];
                    dvy_next  = pos_y[SW-1:0];
                    remx_next = '0;
                    remy_next = '0;
                    qx_next   = '0;
                    qy_next   = '0;
                    step_next = '0;
                    state_next = ugcl_pkg::F_PUSH;
                    if (operation == ugcl_pkg::OP_INSERT || operation == ugcl_pkg::OP_REMOVE)
                    begin
                        item_next.kind = (operation == ugcl_pkg::OP_INSERT)
                                         ? ugcl_pkg::K_INSERT : ugcl_pkg::K_REMOVE;
                        if (pos_invalid)
                        begin
                            item_next.kind   = ugcl_pkg::K_STATUS;
                            item_next.status = ugcl_pkg::ST_INVALID;
                        end
                        else if (32'(particle_id) >= MAX_PARTICLES)
                        begin
                            item_next.kind   = ugcl_pkg::K_STATUS;
                            item_next.status = ugcl_pkg::ST_NOT_FOUND;
                        end
                        else if (operation == ugcl_pkg::OP_INSERT)
                        begin
                            state_next = ugcl_pkg::F_DIV;
                        end
                    end
                    else if (operation == ugcl_pkg::OP_QUERY)
                    begin
                        item_next.kind = ugcl_pkg::K_QUERY;
                        if (32'(particle_id) >= MAX_PARTICLES)
                        begin
                            item_next.kind   = ugcl_pkg::K_STATUS;
                            item_next.status = ugcl_pkg::ST_NOT_FOUND;
                        end
                    end
                    else
                    begin
                        item_next.kind = ugcl_pkg::K_STATUS;
                    end
                end
            end
            ugcl_pkg::F_DIV:
            begin
                // restoring division, one quotient bit per cycle on each axis
                if (tx >= {1'b0, cs})
                begin
                    remx_next = tx - {1'b0, cs};
                    qx_next   = {qx_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    remx_next = tx;
                    qx_next   = {qx_reg[SW-2:0], 1'b0};
                end
                if (ty >= {1'b0, cs})
                begin
                    remy_next = ty - {1'b0, cs};
                    qy_next   = {qy_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    remy_next = ty;
                    qy_next   = {qy_reg[SW-2:0], 1'b0};
                end
                dvx_next  = {dvx_reg[SW-2:0], 1'b0};
                dvy_next  = {dvy_reg[SW-2:0], 1'b0};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(SW - 1))
                begin
                    state_next = ugcl_pkg::F_PUSH;
                end
            end
            ugcl_pkg::F_PUSH:
            begin
                out_valid = 1'b1;
                if (item_reg.kind == ugcl_pkg::K_INSERT)
                begin
                    out_item.col = qx_reg[ugcl_pkg::COORD_W-1:0];
                    out_item.row = qy_reg[ugcl_pkg::COORD_W-1:0];
                    if (!in_range)
                    begin
                        out_item.kind   = ugcl_pkg::K_STATUS;
                        out_item.status = ugcl_pkg::ST_RANGE;
                    end
                end
                if (out_ready)
                begin
                    state_next = ugcl_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = ugcl_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ugcl_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        negx_reg <= negx_next;
        negy_reg <= negy_next;
        remx_reg <= remx_next;
        remy_reg <= remy_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        dvx_reg  <= dvx_next;
        dvy_reg  <= dvy_next;
        step_reg <= step_next;
    end

endmodule

[design/ugcl_queue.sv]
// Short queue between the front end and the table sequencer
module ugcl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ugcl_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output ugcl_pkg::item_t out_item
);

    localparam int PW = $clog2(ugcl_pkg::QUEUE_DEPTH);

    ugcl_pkg::item_t slot_reg [ugcl_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic            push, pop;

    always_comb
    begin
        in_ready  = (count_reg != (PW + 1)'(ugcl_pkg::QUEUE_DEPTH));
        out_valid = (count_reg != '0);
        out_item  = slot_reg[rd_ptr_reg];
        push      = in_valid && in_ready;
        pop       = out_ready && out_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (PW + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PW + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[design/ugcl_back.sv]
// Back end: cell lists, particle records and the result sequencer
`include "assert_macros.svh"
module ugcl_back #(
    parameter int GRID_COLS     = 16,
    parameter int GRID_ROWS     = 16,
    parameter int CELL_CAPACITY = 4,
    parameter int MAX_PARTICLES = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  ugcl_pkg::item_t q_item,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,    // neighbor_id
    output logic [3:0]      m_tuser,    // has_item, status[2:0]
    output logic            m_tlast
);

    localparam int CW       = ugcl_pkg::COORD_W;
    localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
    localparam int NUM_ENT  = NUM_CELLS * CELL_CAPACITY;
    localparam int CELL_AW  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int ENT_AW   = (NUM_ENT > 1) ? $clog2(NUM_ENT) : 1;
    localparam int PART_AW  = $clog2(MAX_PARTICLES);
    localparam int CNT_W    = $clog2(CELL_CAPACITY + 1);
    localparam int CLR_N    = (NUM_CELLS > MAX_PARTICLES) ? NUM_CELLS : MAX_PARTICLES;
    localparam int CLR_W    = $clog2(CLR_N + 1);

    // memories
    logic [7:0]        ent_mem    [NUM_ENT];
    logic [CNT_W-1:0]  cnt_mem    [NUM_CELLS];
    logic [2*CW-1:0]   pcell_mem  [MAX_PARTICLES];
    logic              placed_mem [MAX_PARTICLES];

    logic [7:0]        ent_q;
    logic [CNT_W-1:0]  cnt_q;
    logic [2*CW-1:0]   pcell_q;
    logic              placed_q;

    logic              ent_we, cnt_we, pcell_we, placed_we;
    logic [ENT_AW-1:0] ent_wa;
    logic [7:0]        ent_wd;
    logic [CELL_AW-1:0] cnt_wa;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [PART_AW-1:0] part_wa;
    logic              placed_wd;

    ugcl_pkg::back_state_t state_reg, state_next;
    ugcl_pkg::kind_t   kind_reg, kind_next;
    logic [7:0]        id_reg, id_next;
    ugcl_pkg::status_t status_reg, status_next;
    logic [CW-1:0]     nrow_reg, nrow_next, ncol_reg, ncol_next;
    logic [CW-1:0]     prow_reg, prow_next, pcol_reg, pcol_next;
    logic              placed_reg, placed_next;
    logic [CELL_AW-1:0] cell_reg, cell_next, nflat_reg, nflat_next;
    logic [ENT_AW-1:0] base_reg, base_next;
    logic [CNT_W-1:0]  ncnt_reg, ncnt_next, n_reg, n_next, i_reg, i_next;
    logic              found_reg, found_next;
    logic [1:0]        kr_reg, kr_next, kc_reg, kc_next;
    logic [7:0]        pend_reg, pend_next;
    logic              pend_v_reg, pend_v_next;
    logic [CLR_W-1:0]  clr_reg, clr_next;
    logic              mval_reg;
    logic [7:0]        mid_reg;
    logic              mhas_reg, mlast_reg;
    logic [2:0]        mstat_reg;

    logic              emit, e_has, e_last, out_free;
    logic [7:0]        e_id;
    ugcl_pkg::status_t e_stat;
    logic signed [7:0] rr, cc;
    logic              nb_ok;

    function automatic logic [CELL_AW-1:0] flat_of(input logic [CW-1:0] r,
                                                   input logic [CW-1:0] c);
        flat_of = CELL_AW'(32'(r) * GRID_COLS + 32'(c));
    endfunction

    function automatic logic [ENT_AW-1:0] base_of(input logic [CELL_AW-1:0] f);
        base_of = ENT_AW'(32'(f) * CELL_CAPACITY);
    endfunction

    assign out_free = !mval_reg || m_tready;
    assign m_tvalid = mval_reg;
    assign m_tdata  = mid_reg;
    assign m_tuser  = {mstat_reg, mhas_reg};
    assign m_tlast  = mlast_reg;

    always_comb
    begin
        rr = $signed({2'b00, prow_reg}) + $signed({6'b0, kr_reg}) - 8'sd1;
        cc = $signed({2'b00, pcol_reg}) + $signed({6'b0, kc_reg}) - 8'sd1;
        nb_ok = (rr >= 8'sd0) && (32'(rr) < GRID_ROWS)
                && (cc >= 8'sd0) && (32'(cc) < GRID_COLS);
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        id_next     = id_reg;
        status_next = status_reg;
        nrow_next   = nrow_reg;
        ncol_next   = ncol_reg;
        prow_next   = prow_reg;
        pcol_next   = pcol_reg;
        placed_next = placed_reg;
        cell_next   = cell_reg;
        nflat_next  = nflat_reg;
        base_next   = base_reg;
        ncnt_next   = ncnt_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        found_next  = found_reg;
        kr_next     = kr_reg;
        kc_next     = kc_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        clr_next    = clr_reg;
        q_ready     = 1'b0;
        emit        = 1'b0;
        e_id        = '0;
        e_has       = 1'b0;
        e_last      = 1'b1;
        e_stat      = ugcl_pkg::ST_OK;
        ent_we      = 1'b0;
        ent_wa      = base_reg + ENT_AW'(i_reg) - ENT_AW'(1);
        ent_wd      = ent_q;
        cnt_we      = 1'b0;
        cnt_wa      = cell_reg;
        cnt_wdata   = n_reg - CNT_W'(1);
        pcell_we    = 1'b0;
        placed_we   = 1'b0;
        part_wa     = PART_AW'(id_reg);
        placed_wd   = 1'b0;
        case (state_reg)
            ugcl_pkg::B_CLEAR:
            begin
                cnt_we    = (32'(clr_reg) < NUM_CELLS);
                cnt_wa    = CELL_AW'(clr_reg);
                cnt_wdata = '0;
                placed_we = (32'(clr_reg) < MAX_PARTICLES);
                part_wa   = PART_AW'(clr_reg);
                clr_next  = clr_reg + CLR_W'(1);
                if (32'(clr_reg) == CLR_N - 1)
                begin
                    state_next = ugcl_pkg::B_IDLE;
                end
            end
            ugcl_pkg::B_IDLE:
            begin
                q_ready = q_valid;
                if (q_valid)
                begin
                    kind_next   = q_item.kind;
                    id_next     = q_item.id;
                    status_next = q_item.status;
                    nrow_next   = q_item.row;
                    ncol_next   = q_item.col;
                    state_next  = (q_item.kind == ugcl_pkg::K_STATUS)
                                  ? ugcl_pkg::B_EMIT : ugcl_pkg::B_LOOK;
                end
            end
            ugcl_pkg::B_LOOK:
            begin
                state_next = ugcl_pkg::B_DEC;
            end
            ugcl_pkg::B_DEC:
            begin
                placed_next = placed_q;
                prow_next   = pcell_q[2*CW-1:CW];
                pcol_next   = pcell_q[CW-1:0];
                cell_next   = flat_of(pcell_q[2*CW-1:CW], pcell_q[CW-1:0]);
                base_next   = base_of(flat_of(pcell_q[2*CW-1:CW], pcell_q[CW-1:0]));
                case (kind_reg)
                    ugcl_pkg::K_INSERT:
                    begin
                        if (placed_q && pcell_q == {nrow_reg, ncol_reg})
                        begin
                            status_next = ugcl_pkg::ST_OK;
                            state_next  = ugcl_pkg::B_EMIT;
                        end
                        else
                        begin
                            cell_next  = flat_of(nrow_reg, ncol_reg);
                            state_next = ugcl_pkg::B_CNT_W;
                        end
                    end
                    ugcl_pkg::K_REMOVE:
                    begin
                        if (!placed_q)
                        begin
                            status_next = ugcl_pkg::ST_NOT_FOUND;
                            state_next  = ugcl_pkg::B_EMIT;
                        end
                        else
                        begin
                            placed_we  = 1'b1;
                            state_next = ugcl_pkg::B_TK_C;
                        end
                    end
                    default:
                    begin
                        if (!placed_q)
                        begin
                            status_next = ugcl_pkg::ST_NOT_FOUND;
                            state_next  = ugcl_pkg::B_EMIT;
                        end
                        else
                        begin
                            kr_next     = '0;
                            kc_next     = '0;
                            pend_v_next = 1'b0;
                            state_next  = ugcl_pkg::B_Q_CELL;
                        end
                    end
                endcase
            end
            ugcl_pkg::B_CNT_W:
            begin
                state_next = ugcl_pkg::B_CNT;
            end
            ugcl_pkg::B_CNT:
            begin
                if (cnt_q >= CNT_W'(CELL_CAPACITY))
                begin
                    status_next = ugcl_pkg::ST_FULL;
                    state_next  = ugcl_pkg::B_EMIT;
                end
                else
                begin
                    ncnt_next  = cnt_q;
                    nflat_next = cell_reg;
                    if (placed_reg)
                    begin
                        // move: drop it from the old list first
                        cell_next  = flat_of(prow_reg, pcol_reg);
                        base_next  = base_of(flat_of(prow_reg, pcol_reg));
                        state_next = ugcl_pkg::B_TK_C;
                    end
                    else
                    begin
                        state_next = ugcl_pkg::B_APPEND;
                    end
                end
            end
            ugcl_pkg::B_TK_C:
            begin
                state_next = ugcl_pkg::B_TK_N;
            end
            ugcl_pkg::B_TK_N:
            begin
                n_next     = cnt_q;
                i_next     = '0;
                found_next = 1'b0;
                state_next = ugcl_pkg::B_TK;
            end
            ugcl_pkg::B_TK:
            begin
                if (i_reg == n_reg)
                begin
                    cnt_we = found_reg;
                    if (kind_reg == ugcl_pkg::K_INSERT)
                    begin
                        state_next = ugcl_pkg::B_APPEND;
                    end
                    else
                    begin
                        status_next = found_reg ? ugcl_pkg::ST_OK : ugcl_pkg::ST_NOT_FOUND;
                        state_next  = ugcl_pkg::B_EMIT;
                    end
                end
                else
                begin
                    state_next = ugcl_pkg::B_TK_D;
                end
            end
            ugcl_pkg::B_TK_D:
            begin
                // after the hit, each later entry moves down one slot
                if (found_reg)
                begin
                    ent_we = 1'b1;
                end
                else if (ent_q == id_reg)
                begin
                    found_next = 1'b1;
                end
                i_next     = i_reg + CNT_W'(1);
                state_next = ugcl_pkg::B_TK;
            end
            ugcl_pkg::B_APPEND:
            begin
                ent_we      = 1'b1;
                ent_wa      = base_of(nflat_reg) + ENT_AW'(ncnt_reg);
                ent_wd      = id_reg;
                cnt_we      = 1'b1;
                cnt_wa      = nflat_reg;
                cnt_wdata   = ncnt_reg + CNT_W'(1);
                pcell_we    = 1'b1;
                placed_we   = 1'b1;
                placed_wd   = 1'b1;
                status_next = ugcl_pkg::ST_OK;
                state_next  = ugcl_pkg::B_EMIT;
            end
            ugcl_pkg::B_Q_CELL:
            begin
                if (kr_reg == 2'd3)
                begin
                    state_next = ugcl_pkg::B_Q_END;
                end
                else
                begin
                    if (kc_reg == 2'd2)
                    begin
                        kc_next = '0;
                        kr_next = kr_reg + 2'd1;
                    end
                    else
                    begin
                        kc_next = kc_reg + 2'd1;
                    end
                    if (nb_ok)
                    begin
                        cell_next  = flat_of(CW'(rr), CW'(cc));
                        base_next  = base_of(flat_of(CW'(rr), CW'(cc)));
                        state_next = ugcl_pkg::B_Q_CW;
                    end
                end
            end
            ugcl_pkg::B_Q_CW:
            begin
                state_next = ugcl_pkg::B_Q_CNT;
            end
            ugcl_pkg::B_Q_CNT:
            begin
                n_next     = cnt_q;
                i_next     = '0;
                state_next = ugcl_pkg::B_Q_ENT;
            end
            ugcl_pkg::B_Q_ENT:
            begin
                state_next = (i_reg == n_reg) ? ugcl_pkg::B_Q_CELL : ugcl_pkg::B_Q_DAT;
            end
            ugcl_pkg::B_Q_DAT:
            begin
                // one word held back so the final one can carry tlast
                if (!pend_v_reg || out_free)
                begin
                    emit        = pend_v_reg;
                    e_id        = pend_reg;
                    e_has       = 1'b1;
                    e_last      = 1'b0;
                    pend_next   = ent_q;
                    pend_v_next = 1'b1;
                    i_next      = i_reg + CNT_W'(1);
                    state_next  = ugcl_pkg::B_Q_ENT;
                end
            end
            ugcl_pkg::B_Q_END:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    e_id        = pend_v_reg ? pend_reg : 8'd0;
                    e_has       = pend_v_reg;
                    pend_v_next = 1'b0;
                    state_next  = ugcl_pkg::B_IDLE;
                end
            end
            ugcl_pkg::B_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_stat     = status_reg;
                    state_next = ugcl_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = ugcl_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ugcl_pkg::B_CLEAR;
            clr_reg    <= '0;
            pend_v_reg <= 1'b0;
            mval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pend_v_reg <= pend_v_next;
            if (emit)
            begin
                mval_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                mval_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        id_reg     <= id_next;
        status_reg <= status_next;
        nrow_reg   <= nrow_next;
        ncol_reg   <= ncol_next;
        prow_reg   <= prow_next;
        pcol_reg   <= pcol_next;
        placed_reg <= placed_next;
        cell_reg   <= cell_next;
        nflat_reg  <= nflat_next;
        base_reg   <= base_next;
        ncnt_reg   <= ncnt_next;
        n_reg      <= n_next;
        i_reg      <= i_next;
        found_reg  <= found_next;
        kr_reg     <= kr_next;
        kc_reg     <= kc_next;
        pend_reg   <= pend_next;
        if (emit)
        begin
            mid_reg   <= e_id;
            mhas_reg  <= e_has;
            mlast_reg <= e_last;
            mstat_reg <= e_stat;
        end
    end

    // memory ports: reads always follow the address registers
    always_ff @(posedge clk)
    begin
        ent_q    <= ent_mem[base_reg + ENT_AW'(i_reg)];
        cnt_q    <= cnt_mem[cell_reg];
        pcell_q  <= pcell_mem[PART_AW'(id_reg)];
        placed_q <= placed_mem[PART_AW'(id_reg)];
        if (ent_we)
        begin
            ent_mem[ent_wa] <= ent_wd;
        end
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wdata;
        end
        if (pcell_we)
        begin
            pcell_mem[part_wa] <= {nrow_reg, ncol_reg};
        end
        if (placed_we)
        begin
            placed_mem[part_wa] <= placed_wd;
        end
    end

    `UGCL_ASSERT(a_cnt_bound, clk, rst_n, !cnt_we || cnt_wdata <= CNT_W'(CELL_CAPACITY))
    `UGCL_ASSERT(a_pop_idle, clk, rst_n, !q_ready || state_reg == ugcl_pkg::B_IDLE)
    `UGCL_ASSERT(a_pend_clear, clk, rst_n, !(state_reg == ugcl_pkg::B_IDLE && pend_v_reg))
    `UGCL_ASSERT_NEXT(a_emit_valid, clk, rst_n, emit, mval_reg)

endmodule

[design/uniform_grid_cell_list.sv]
// Top level of the uniform grid cell list binning table
//
// channel   dir   handshake          payload
// s_*       in    tvalid/tready      tdata: particle_id, pos_x, pos_y; tuser: operation, pos_invalid
// m_*       out   tvalid/tready      tdata: neighbor_id; tuser: has_item, status; tlast: last
// apb       in    psel/penable       reg 0 at 0x0: cell_size
//
// Insert: the result word waits on the 23-step restoring divider in the front end,
// and also on a walk of the old list when the particle moves out of a list of entries.
// Query: each neighbor cell on the grid has its count read and then each of its entries.
// After reset the back end clears counts and placed flags, one entry a cycle, through
// max(GRID_COLS*GRID_ROWS, MAX_PARTICLES) entries; words queue up meanwhile.
// A stalled output holds the back end; the front end keeps filling its two-word queue.
module uniform_grid_cell_list #(
    parameter int GRID_COLS     = 16,
    parameter int GRID_ROWS     = 16,
    parameter int CELL_CAPACITY = 4,
    parameter int MAX_PARTICLES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // particle_id[7:0], pos_x[31:8], pos_y[55:32]
    input  logic [2:0]  s_tuser,    // operation[1:0], pos_invalid[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // neighbor_id[7:0]
    output logic [3:0]  m_tuser,    // has_item[0], status[3:1]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [ugcl_pkg::SIZE_W-1:0] cell_size_reg;
    logic                        f_valid, f_ready, b_valid, b_ready;
    ugcl_pkg::item_t             f_item, b_item;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {9'd0, cell_size_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= ugcl_pkg::SIZE_W'(8192);
        end
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        begin
            cell_size_reg <= pwdata[ugcl_pkg::SIZE_W-1:0];
        end
    end

    ugcl_front #(
        .GRID_COLS     (GRID_COLS),
        .GRID_ROWS     (GRID_ROWS),
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .operation   (s_tuser[1:0]),
        .particle_id (s_tdata[7:0]),
        .pos_x       (s_tdata[31:8]),
        .pos_y       (s_tdata[55:32]),
        .pos_invalid (s_tuser[2]),
        .cell_size   (cell_size_reg),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_item    (f_item)
    );

    ugcl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    ugcl_back #(
        .GRID_COLS     (GRID_COLS),
        .GRID_ROWS     (GRID_ROWS),
        .CELL_CAPACITY (CELL_CAPACITY),
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (b_valid),
        .q_ready  (b_ready),
        .q_item   (b_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
